@@ sv/byte_ring_buffer_unit_macros.svh @@
// Assertion macros used by the ring buffer back end.
`ifndef BYTE_RING_BUFFER_UNIT_MACROS_SVH
`define BYTE_RING_BUFFER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define BRB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BRB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BRB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BRB_ASSERT(lbl, clk, rst, prop, msg)
`define BRB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define BRB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ sv/brb_pkg.sv @@
package brb_pkg;

   localparam int DATA_W = 8;
   localparam int LEN_W  = 7;
   localparam int CAP_W  = 13;
   localparam int FILL_W = 13;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_READ,
      OP_CLEAR
   } op_kind_type;

   typedef enum logic {
      BK_IDLE,
      BK_READ
   } back_state_type;

   // Classified command handed from the front end to the back end.
   typedef struct packed {
      op_kind_type       kind;
      logic [DATA_W-1:0] data;
      logic [LEN_W-1:0]  len;
   } op_type;

   typedef struct packed {
      logic [DATA_W-1:0] data_out;
      logic              data_valid;
      logic              last;
      status_type        status;
      logic [FILL_W-1:0] fill_level;
   } rsp_type;

   function automatic rsp_type make_rsp(input logic [DATA_W-1:0] d,
                                        input logic              v,
                                        input logic              l,
                                        input status_type        s,
                                        input logic [FILL_W-1:0] f);
      rsp_type r;
      r.data_out   = d;
      r.data_valid = v;
      r.last       = l;
      r.status     = s;
      r.fill_level = f;
      return r;
   endfunction

endpackage

@@ sv/brb_if.sv @@
interface brb_req_if;
   logic                       valid;
   logic                       ready;
   logic [1:0]                 cmd;
   logic [brb_pkg::DATA_W-1:0] data_in;
   logic [brb_pkg::LEN_W-1:0]  read_len;

   modport source (output valid, cmd, data_in, read_len, input ready);
   modport sink   (input valid, cmd, data_in, read_len, output ready);
endinterface

interface brb_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [brb_pkg::DATA_W-1:0] data_out;
   logic                       data_valid;
   logic                       last;
   logic [1:0]                 status;
   logic [brb_pkg::FILL_W-1:0] fill_level;

   modport source (output valid, data_out, data_valid, last, status, fill_level,
                   input ready);
   modport sink   (input valid, data_out, data_valid, last, status, fill_level,
                   output ready);
endinterface

interface brb_csr_if;
   logic                      valid;
   logic                      ready;
   logic [brb_pkg::CAP_W-1:0] capacity;

   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

@@ sv/brb_ram.sv @@
module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ sv/brb_front.sv @@
module brb_front #(
   parameter int MAX_BURST = 64
) (
   brb_req_if.sink          req,
   output logic             push_valid,
   input  logic             push_ready,
   output brb_pkg::op_type  push_data
);

   localparam logic [brb_pkg::LEN_W-1:0] BURST_MAX = brb_pkg::LEN_W'(MAX_BURST);

   logic [brb_pkg::LEN_W-1:0] len_sat;

   // Command three is taken and dropped without a queue entry.
   assign req.ready = push_ready;

   always_comb begin
      len_sat = (req.read_len > BURST_MAX) ? BURST_MAX : req.read_len;
      push_data.data = req.data_in;
      push_data.len  = len_sat;
      push_data.kind = brb_pkg::OP_WRITE;
      push_valid     = 1'b0;
      case (req.cmd)
         brb_pkg::CMD_WRITE: begin
            push_data.kind = brb_pkg::OP_WRITE;
            push_valid     = req.valid;
         end
         brb_pkg::CMD_READ: begin
            push_data.kind = brb_pkg::OP_READ;
            push_valid     = req.valid;
         end
         brb_pkg::CMD_CLEAR: begin
            push_data.kind = brb_pkg::OP_CLEAR;
            push_valid     = req.valid;
         end
         default: begin
            push_valid = 1'b0;
         end
      endcase
   end

endmodule

@@ sv/brb_queue.sv @@
module brb_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push_valid,
   output logic            push_ready,
   input  brb_pkg::op_type push_data,
   output logic            pop_valid,
   input  logic            pop_ready,
   output brb_pkg::op_type pop_data
);

   brb_pkg::op_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ sv/brb_back.sv @@
`include "byte_ring_buffer_unit_macros.svh"

module brb_back #(
   parameter int DEPTH = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            pop_valid,
   output logic            pop_ready,
   input  brb_pkg::op_type pop_data,
   brb_rsp_if.source       rsp,
   brb_csr_if.sink         csr
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EW    = (CNT_W > brb_pkg::CAP_W) ? CNT_W : brb_pkg::CAP_W;
   localparam logic [EW-1:0]    DEPTH_E = EW'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   brb_pkg::back_state_type state_ff, state_in;
   logic [PTR_W-1:0]          rp_ff, rp_in;
   logic [PTR_W-1:0]          wp_ff, wp_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CNT_W-1:0]          cap_ff, cap_in;
   logic [brb_pkg::LEN_W-1:0] rem_ff, rem_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   brb_pkg::rsp_type          out_ff, out_in;

   logic                      out_free;
   logic                      ram_we, ram_re;
   logic [PTR_W-1:0]          ram_raddr;
   logic [brb_pkg::DATA_W-1:0] ram_rdata;
   logic [EW-1:0]             cap_req;
   logic [EW-1:0]             rem_wide, cnt_wide;
   logic [brb_pkg::LEN_W-1:0] burst_n;
   logic [PTR_W-1:0]          rp_next;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p,
                                                 input logic [CNT_W-1:0] cap);
      logic [CNT_W-1:0] n;
      n = CNT_W'(p) + 1'b1;
      return (n >= cap) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   brb_ram #(
      .WIDTH (brb_pkg::DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (wp_ff),
      .wdata (pop_data.data),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign csr.ready      = 1'b1;
   assign rsp.valid      = rsp_valid_ff;
   assign rsp.data_out   = out_ff.data_out;
   assign rsp.data_valid = out_ff.data_valid;
   assign rsp.last       = out_ff.last;
   assign rsp.status     = out_ff.status;
   assign rsp.fill_level = out_ff.fill_level;

   assign out_free = !rsp_valid_ff || rsp.ready;
   assign rem_wide = EW'(rem_ff);
   assign cnt_wide = EW'(cnt_ff);
   assign rp_next  = next_ptr(rp_ff, cap_ff);
   assign burst_n  = (EW'(pop_data.len) < cnt_wide) ? pop_data.len
                                                   : brb_pkg::LEN_W'(cnt_ff);
   assign cap_req  = EW'(csr.capacity);

   always_comb begin
      state_in     = state_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      cap_in       = cap_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_in       = out_ff;
      pop_ready    = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_raddr    = rp_ff;

      case (state_ff)
         brb_pkg::BK_IDLE: begin
            if (pop_valid && out_free) begin
               pop_ready    = 1'b1;
               rsp_valid_in = 1'b1;
               case (pop_data.kind)
                  brb_pkg::OP_WRITE: begin
                     if (cnt_ff >= cap_ff) begin
                        out_in = brb_pkg::make_rsp('0, 1'b0, 1'b1, brb_pkg::STS_FULL,
                                                   brb_pkg::FILL_W'(cnt_ff));
                     end else begin
                        ram_we = 1'b1;
                        wp_in  = next_ptr(wp_ff, cap_ff);
                        cnt_in = cnt_ff + 1'b1;
                        out_in = brb_pkg::make_rsp('0, 1'b0, 1'b1, brb_pkg::STS_OK,
                                                   brb_pkg::FILL_W'(cnt_in));
                     end
                  end
                  brb_pkg::OP_READ: begin
                     if (cnt_ff == '0) begin
                        out_in = brb_pkg::make_rsp('0, 1'b0, 1'b1, brb_pkg::STS_EMPTY,
                                                   '0);
                     end else if (pop_data.len == '0) begin
                        out_in = brb_pkg::make_rsp('0, 1'b0, 1'b1, brb_pkg::STS_OK,
                                                   brb_pkg::FILL_W'(cnt_ff));
                     end else begin
                        // Fetch the oldest byte; the burst streams from BK_READ.
                        rsp_valid_in = rsp_valid_ff && !rsp.ready;
                        ram_re       = 1'b1;
                        rem_in       = burst_n;
                        state_in     = brb_pkg::BK_READ;
                     end
                  end
                  brb_pkg::OP_CLEAR: begin
                     rp_in  = '0;
                     wp_in  = '0;
                     cnt_in = '0;
                     out_in = brb_pkg::make_rsp('0, 1'b0, 1'b1, brb_pkg::STS_OK, '0);
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && !rsp.ready;
                  end
               endcase
            end
         end
         brb_pkg::BK_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               cnt_in       = cnt_ff - 1'b1;
               rem_in       = rem_ff - 1'b1;
               rp_in        = rp_next;
               out_in       = brb_pkg::make_rsp(ram_rdata, 1'b1, (rem_ff == 1),
                                                brb_pkg::STS_OK,
                                                brb_pkg::FILL_W'(cnt_in));
               if (rem_ff == 1) begin
                  state_in = brb_pkg::BK_IDLE;
               end else begin
                  // Prefetch the following byte while this one is shown.
                  ram_re    = 1'b1;
                  ram_raddr = rp_next;
               end
            end
         end
         default: begin
            state_in = brb_pkg::BK_IDLE;
         end
      endcase

      // A capacity write reinitializes the ring.
      if (csr.valid) begin
         if (cap_req == '0) begin
            cap_in = CNT_W'(1);
         end else if (cap_req > DEPTH_E) begin
            cap_in = DEPTH_C;
         end else begin
            cap_in = CNT_W'(cap_req);
         end
         rp_in  = '0;
         wp_in  = '0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= brb_pkg::BK_IDLE;
         rp_ff        <= '0;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         cap_ff       <= DEPTH_C;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rp_ff        <= rp_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         cap_ff       <= cap_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   `BRB_ASSERT(a_cnt_le_cap, clock, reset, cnt_ff <= cap_ff, "stored count above capacity")
   `BRB_ASSERT(a_ptr_in_ring, clock, reset, CNT_W'(rp_ff) < cap_ff && CNT_W'(wp_ff) < cap_ff, "pointer outside ring")
   `BRB_ASSERT_IMP(a_burst_backed, clock, reset, state_ff == brb_pkg::BK_READ, rem_ff != '0 && rem_wide <= cnt_wide, "burst longer than stored bytes")
   `BRB_ASSERT_NXT(a_burst_ends, clock, reset, state_ff == brb_pkg::BK_READ && out_free && rem_ff == 1, state_ff == brb_pkg::BK_IDLE && rsp_valid_ff && out_ff.last, "burst did not end on last byte")

endmodule

@@ sv/byte_ring_buffer_unit.sv @@
// Channel  Dir  Payload                                          Transaction
// req_ch   in   cmd, data_in, read_len                           valid & ready
// rsp_ch   out  data_out, data_valid, last, status, fill_level   valid & ready
// csr_ch   in   capacity                                         valid & ready
//
// Write, clear and short reads are answered from the idle state; a read burst
// fetches its first byte, then one byte per cycle while rsp_ch does not stall.
// Reset clears pointers, count and handshakes and sets capacity to DEPTH;
// store contents stay undefined and no clearing pass is run.
// A stalled rsp_ch holds the output register; the two-entry command queue
// keeps req_ch taking transactions until it fills.
module byte_ring_buffer_unit #(
   parameter int DEPTH     = 4096,
   parameter int MAX_BURST = 64
) (
   input  logic       clock,
   input  logic       reset,
   brb_req_if.sink    req_ch,
   brb_rsp_if.source  rsp_ch,
   brb_csr_if.sink    csr_ch
);

   // Command queue handshake between the front and back ends.
   logic            push_valid;
   logic            push_ready;
   brb_pkg::op_type push_data;
   logic            pop_valid;
   logic            pop_ready;
   brb_pkg::op_type pop_data;

   // Decode commands, saturate the burst length, drop the unused code.
   brb_front #(
      .MAX_BURST (MAX_BURST)
   ) u_front (
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Decouple the request side from the result side.
   brb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // Execute commands against the ring storage and drive the results.
   brb_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_ch),
      .csr       (csr_ch)
   );

endmodule
